@@ rtl/core/rau_pkg.sv @@
// Package for the rational arithmetic unit: widths, codes and command/status types.
package rau_pkg;
  localparam int unsigned OperandWidth = 32;
  localparam int unsigned MagWidth     = 2 * OperandWidth;
  localparam int unsigned CntWidth     = $clog2(MagWidth + 1);

  localparam logic [2:0] OpAdd = 3'd0;
  localparam logic [2:0] OpSub = 3'd1;
  localparam logic [2:0] OpMul = 3'd2;
  localparam logic [2:0] OpDiv = 3'd3;
  localparam logic [2:0] OpRed = 3'd4;  // reduce a only; codes above alias to it

  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatDivZero = 2'd1;
  localparam logic [1:0] StatBothZero = 2'd2;

  typedef struct packed {
    logic [2:0]              op;
    logic [OperandWidth-1:0] a_num;
    logic [OperandWidth-1:0] a_den;
    logic [OperandWidth-1:0] b_num;
    logic [OperandWidth-1:0] b_den;
  } req_t;

  typedef struct packed {
    logic [MagWidth-1:0] res_num;
    logic [MagWidth-1:0] res_den;
    logic [1:0]          status;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request, form products
    logic sum;       // form numerator sum / pick pair
    logic gcd_init;  // prev=num, cur=den
    logic div_start; // start a divide
    logic [1:0] div_sel; // 0 gcd step, 1 num/g, 2 den/g
    logic gcd_step;  // take remainder into the Euclid pair
    logic q_num;     // store quotient as numerator
    logic q_den;     // store quotient as denominator
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_zero;  // divide request with zero b numerator
    logic both_zero; // unreduced pair both zero
    logic cur_zero;  // Euclid current remainder is zero
    logic div_done;  // divider finished
  } stat_t;

  localparam logic [1:0] SelGcd = 2'd0;
  localparam logic [1:0] SelNum = 2'd1;
  localparam logic [1:0] SelDen = 2'd2;
endpackage

@@ rtl/core/rau_if.sv @@
// Valid/ready channel interface for request and result transactions.
interface rau_req_if;
  logic          valid;
  logic          ready;
  rau_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rau_rsp_if;
  logic          valid;
  logic          ready;
  rau_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/rau_divider.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
module rau_divider (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [rau_pkg::MagWidth-1:0] dividend_i,
  input  logic [rau_pkg::MagWidth-1:0] divisor_i,
  output logic                         done_o,
  output logic [rau_pkg::MagWidth-1:0] quot_o,
  output logic [rau_pkg::MagWidth-1:0] rem_o
);
  localparam int unsigned W = rau_pkg::MagWidth;
  logic [W-1:0] quot_q, quot_d, rem_q, rem_d, dvs_q;
  logic [rau_pkg::CntWidth-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [W:0] trial;

  // load on start, else one shift-subtract step while busy
  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quot_q[W-1]} - {1'b0, dvs_q};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      cnt_d  = rau_pkg::CntWidth'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[W]) begin
        rem_d  = trial[W-1:0];
        quot_d = {quot_q[W-2:0], 1'b1};
      end else begin
        rem_d  = {rem_q[W-2:0], quot_q[W-1]};
        quot_d = {quot_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == rau_pkg::CntWidth'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (start_i) dvs_q <= divisor_i;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;
endmodule

@@ rtl/core/rau_datapath.sv @@
// Datapath: operand load, cross products, sum, Euclid pair and output scaling.
module rau_datapath (
  input  logic                clk_i,
  input  rau_pkg::cmd_t       cmd_i,
  input  rau_pkg::req_t       req_i,
  input  logic                div_done_i,
  input  logic [rau_pkg::MagWidth-1:0] div_quot_i,
  input  logic [rau_pkg::MagWidth-1:0] div_rem_i,
  output logic [rau_pkg::MagWidth-1:0] div_dvd_o,
  output logic [rau_pkg::MagWidth-1:0] div_dvs_o,
  output rau_pkg::stat_t      stat_o,
  output logic [rau_pkg::MagWidth-1:0] res_num_o,
  output logic [rau_pkg::MagWidth-1:0] res_den_o
);
  localparam int unsigned OW = rau_pkg::OperandWidth;
  localparam int unsigned W  = rau_pkg::MagWidth;

  logic [2:0]    op_q;
  logic [OW-1:0] an_m, ad_m, bn_m, bd_m;
  logic          an_s, ad_s, bn_s, bd_s;
  logic [W-1:0]  p0_q, p1_q, p2_q, p3_q;  // |an*bd|, |bn*ad|, |an*bn|, |ad*bd|
  logic [W-1:0]  p4_q;                     // |ad*bn|
  logic          s0_q, s1_q, s2_q, s3_q, s4_q, bnz_q;
  logic [OW-1:0] an_mq, ad_mq;
  logic          an_sq, ad_sq;
  logic [W-1:0]  num_q, den_q, prev_q, cur_q, rn_q, rd_q;
  logic          num_neg_q, den_neg_q, par_q;
  logic [W:0]    sum_mag;
  logic          sum_neg, s1_eff;
  logic [W-1:0]  num_d, den_d;
  logic          num_nd, den_nd;
  logic          g_neg, q_neg;

  function automatic logic [OW:0] mag_of(input logic [OW-1:0] v);
    mag_of = v[OW-1] ? {1'b1, OW'(-v)} : {1'b0, v};
  endfunction

  assign {an_s, an_m} = mag_of(req_i.a_num);
  assign {ad_s, ad_m} = mag_of(req_i.a_den);
  assign {bn_s, bn_m} = mag_of(req_i.b_num);
  assign {bd_s, bd_m} = mag_of(req_i.b_den);

  // products, captured with the request (one 32x32 multiply each)
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= req_i.op;
      p0_q  <= W'(an_m) * W'(bd_m);
      p1_q  <= W'(bn_m) * W'(ad_m);
      p2_q  <= W'(an_m) * W'(bn_m);
      p3_q  <= W'(ad_m) * W'(bd_m);
      p4_q  <= W'(ad_m) * W'(bn_m);
      s0_q  <= an_s ^ bd_s;
      s1_q  <= bn_s ^ ad_s;
      s2_q  <= an_s ^ bn_s;
      s3_q  <= ad_s ^ bd_s;
      s4_q  <= ad_s ^ bn_s;
      bnz_q <= (bn_m == '0) && !bn_s;
      an_mq <= an_m;
      ad_mq <= ad_m;
      an_sq <= an_s;
      ad_sq <= ad_s;
    end
  end

  // signed-magnitude sum of the two cross products
  always_comb begin
    s1_eff = s1_q ^ (op_q == rau_pkg::OpSub);
    if ((s0_q && p0_q != '0) == (s1_eff && p1_q != '0) || p0_q == '0 || p1_q == '0) begin
      sum_mag = (s0_q == s1_eff || p0_q == '0 || p1_q == '0) ?
                {1'b0, p0_q} + {1'b0, p1_q} : {1'b0, p0_q} - {1'b0, p1_q};
      sum_neg = (p0_q != '0) ? s0_q : s1_eff;
    end else if (p0_q >= p1_q) begin
      sum_mag = {1'b0, p0_q - p1_q};
      sum_neg = s0_q;
    end else begin
      sum_mag = {1'b0, p1_q - p0_q};
      sum_neg = s1_eff;
    end
    if (sum_mag == '0) sum_neg = 1'b0;
  end

  // select the unreduced pair (each product is at most 2^62, so a sum
  // of two stays within 2^63 and fits the magnitude width)
  always_comb begin
    unique case (op_q)
      rau_pkg::OpAdd, rau_pkg::OpSub: begin
        num_d = sum_mag[W-1:0]; num_nd = sum_neg;
        den_d = p3_q;           den_nd = s3_q && p3_q != '0;
      end
      rau_pkg::OpMul: begin
        num_d = p2_q; num_nd = s2_q && p2_q != '0;
        den_d = p3_q; den_nd = s3_q && p3_q != '0;
      end
      rau_pkg::OpDiv: begin
        num_d = p0_q; num_nd = s0_q && p0_q != '0;
        den_d = p4_q; den_nd = s4_q && p4_q != '0;
      end
      default: begin
        num_d = W'(an_mq); num_nd = an_sq;
        den_d = W'(ad_mq); den_nd = ad_sq;
      end
    endcase
  end

  // unreduced pair, Euclid pair and scaled outputs
  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      num_q     <= num_d;
      den_q     <= den_d;
      num_neg_q <= num_nd;
      den_neg_q <= den_nd;
    end
    if (cmd_i.gcd_init) begin
      prev_q <= num_q;
      cur_q  <= den_q;
      par_q  <= 1'b0;
    end else if (cmd_i.gcd_step) begin
      prev_q <= cur_q;
      cur_q  <= div_rem_i;
      par_q  <= ~par_q;
    end
    if (cmd_i.q_num && div_done_i) rn_q <= q_neg ? W'(-div_quot_i) : div_quot_i;
    if (cmd_i.q_den && div_done_i) rd_q <= q_neg ? W'(-div_quot_i) : div_quot_i;
  end

  assign g_neg = par_q ? den_neg_q : num_neg_q;
  assign q_neg = (div_quot_i != '0) &&
                 ((cmd_i.q_num ? num_neg_q : den_neg_q) != g_neg);

  always_comb begin
    unique case (cmd_i.div_sel)
      rau_pkg::SelNum: begin div_dvd_o = num_q; div_dvs_o = prev_q; end
      rau_pkg::SelDen: begin div_dvd_o = den_q; div_dvs_o = prev_q; end
      default:         begin div_dvd_o = prev_q; div_dvs_o = cur_q; end
    endcase
  end

  assign stat_o.div_zero  = (op_q == rau_pkg::OpDiv) && bnz_q;
  assign stat_o.both_zero = (num_d == '0) && (den_d == '0) && !sum_mag[W];
  assign stat_o.cur_zero  = (cur_q == '0);
  assign stat_o.div_done  = div_done_i;
  assign res_num_o = rn_q;
  assign res_den_o = rd_q;
endmodule

@@ rtl/core/rau_ctrl.sv @@
// Controller: sequences load, Euclid iterations, output divides and handshakes.
module rau_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  output logic [1:0]     status_o,
  input  rau_pkg::stat_t stat_i,
  output rau_pkg::cmd_t  cmd_o
);
  typedef enum logic [2:0] {
    StIdle, StSum, StCheck, StGcd, StGcdWait, StNumWait, StDenWait, StOut
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] status_q, status_d;

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    cmd_o    = '0;
    cmd_o.div_sel = rau_pkg::SelGcd;
    unique case (state_q)
      StIdle: if (req_valid_i) begin
        cmd_o.load = 1'b1;
        state_d = StSum;
      end
      StSum: begin
        cmd_o.sum = 1'b1;
        if (stat_i.div_zero) begin
          status_d = rau_pkg::StatDivZero; state_d = StOut;
        end else if (stat_i.both_zero) begin
          status_d = rau_pkg::StatBothZero; state_d = StOut;
        end else begin
          status_d = rau_pkg::StatOk; state_d = StCheck;
        end
      end
      StCheck: begin
        cmd_o.gcd_init = 1'b1;
        state_d = StGcd;
      end
      StGcd: begin
        if (stat_i.cur_zero) begin
          cmd_o.div_sel = rau_pkg::SelNum;
          cmd_o.div_start = 1'b1;
          state_d = StNumWait;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = StGcdWait;
        end
      end
      StGcdWait: if (stat_i.div_done) begin
        cmd_o.gcd_step = 1'b1;
        state_d = StGcd;
      end
      StNumWait: begin
        cmd_o.div_sel = rau_pkg::SelNum;
        cmd_o.q_num = 1'b1;
        if (stat_i.div_done) begin
          cmd_o.q_num = 1'b1;
          state_d = StDenWait;
        end
      end
      StDenWait: begin
        cmd_o.div_sel = rau_pkg::SelDen;
        cmd_o.q_den = 1'b1;
        if (state_q != state_d) cmd_o.q_den = 1'b1;
        if (stat_i.div_done) state_d = StOut;
      end
      StOut: if (rsp_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
    // start the denominator divide right after the numerator one finishes
    if (state_q == StNumWait && stat_i.div_done) begin
      cmd_o.div_start = 1'b1;
      cmd_o.div_sel = rau_pkg::SelDen;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      status_q <= rau_pkg::StatOk;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

  assign req_ready_o = (state_q == StIdle);
  assign rsp_valid_o = (state_q == StOut);
  assign status_o    = status_q;
endmodule

@@ rtl/core/rational_arithmetic_unit.sv @@
// Top level of the rational arithmetic unit with gcd reduction.
//   channel  dir  payload                                 transaction
//   req      in   op, a_num, a_den, b_num, b_den          valid & ready
//   rsp      out  res_num, res_den, status                valid & ready
// One request at a time. Processing runs setup (load, sum, Euclid init), then a
// divide for each Euclid remainder step (a 64-step shift-subtract divider, up to
// ~93 steps), then the two output divides for numerator and denominator.
// Error cases go from the sum state straight to the output state, skipping the divides.
// Reset clears the controller and the divider control only.
// The result is held until taken; a new request waits until then.
module rational_arithmetic_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  rau_req_if.sink   req_i,
  rau_rsp_if.source rsp_o
);
  rau_pkg::cmd_t  cmd;
  rau_pkg::stat_t stat;
  logic [rau_pkg::MagWidth-1:0] dvd, dvs, quot, rem, rn, rd;
  logic div_done;
  logic [1:0] status;

  rau_divider u_div (
    .clk_i, .rst_ni, .start_i(cmd.div_start), .dividend_i(dvd), .divisor_i(dvs),
    .done_o(div_done), .quot_o(quot), .rem_o(rem)
  );

  rau_datapath u_dp (
    .clk_i, .cmd_i(cmd), .req_i(req_i.data), .div_done_i(div_done),
    .div_quot_i(quot), .div_rem_i(rem), .div_dvd_o(dvd), .div_dvs_o(dvs),
    .stat_o(stat), .res_num_o(rn), .res_den_o(rd)
  );

  rau_ctrl u_ctrl (
    .clk_i, .rst_ni, .req_valid_i(req_i.valid), .req_ready_o(req_i.ready),
    .rsp_valid_o(rsp_o.valid), .rsp_ready_i(rsp_o.ready), .status_o(status),
    .stat_i(stat), .cmd_o(cmd)
  );

  assign rsp_o.data.res_num = (status == rau_pkg::StatOk) ? rn : '0;
  assign rsp_o.data.res_den = (status == rau_pkg::StatOk) ? rd : '0;
  assign rsp_o.data.status  = status;
endmodule

@@ verif/rau_checker.sv @@
// Checker for the rational arithmetic unit: predicts each result and compares.
`timescale 1ns / 100ps
module rau_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  input  logic           req_ready_i,
  input  rau_pkg::req_t  req_data_i,
  input  logic           rsp_valid_i,
  input  logic           rsp_ready_i,
  input  rau_pkg::rsp_t  rsp_data_i,
  output int unsigned    errors_o,
  output int unsigned    pending_o
);
  typedef struct {
    bit          neg;
    bit [64:0]   mag;
  } smag_t;

  rau_pkg::rsp_t expected_q[$];

  function automatic smag_t load_part(logic [rau_pkg::OperandWidth-1:0] raw);
    smag_t r;
    r.neg = raw[rau_pkg::OperandWidth-1];
    r.mag = r.neg ? (65'(1) << rau_pkg::OperandWidth) - 65'(raw) : 65'(raw);
    return r;
  endfunction

  function automatic smag_t mag_mul(smag_t x, smag_t y);
    smag_t r;
    r.mag = x.mag * y.mag;
    r.neg = (r.mag != 0) && (x.neg != y.neg);
    return r;
  endfunction

  function automatic smag_t mag_add(smag_t x, smag_t y);
    smag_t r;
    if (x.neg == y.neg) begin
      r.mag = x.mag + y.mag;
      r.neg = x.neg;
    end else if (x.mag >= y.mag) begin
      r.mag = x.mag - y.mag;
      r.neg = x.neg;
    end else begin
      r.mag = y.mag - x.mag;
      r.neg = y.neg;
    end
    if (r.mag == 0) r.neg = 0;
    return r;
  endfunction

  // quotient of a part by the signed Euclid divisor, back to two's complement
  function automatic logic [63:0] scaled(smag_t x, smag_t g);
    bit [64:0] q;
    q = x.mag / g.mag;
    return ((q != 0) && (x.neg != g.neg)) ? 64'(-q) : q[63:0];
  endfunction

  function automatic rau_pkg::rsp_t reduced_fraction(rau_pkg::req_t rq);
    smag_t an, ad, bn, bd, num, den, g;
    bit [64:0] prev, cur, t;
    bit parity;
    rau_pkg::rsp_t r;
    an = load_part(rq.a_num);
    ad = load_part(rq.a_den);
    bn = load_part(rq.b_num);
    bd = load_part(rq.b_den);
    r = '0;
    r.status = rau_pkg::StatOk;
    case (rq.op)
      rau_pkg::OpAdd, rau_pkg::OpSub: begin
        if (rq.op == rau_pkg::OpSub) bn.neg = (bn.mag != 0) && !bn.neg;
        num = mag_add(mag_mul(an, bd), mag_mul(bn, ad));
        den = mag_mul(ad, bd);
      end
      rau_pkg::OpMul: begin
        num = mag_mul(an, bn);
        den = mag_mul(ad, bd);
      end
      rau_pkg::OpDiv: begin
        if (bn.mag == 0) begin
          r.status = rau_pkg::StatDivZero;
          return r;
        end
        num = mag_mul(an, bd);
        den = mag_mul(ad, bn);
      end
      default: begin
        num = an;
        den = ad;
      end
    endcase
    if (num.mag == 0 && den.mag == 0) begin
      r.status = rau_pkg::StatBothZero;
      return r;
    end
    prev = num.mag;
    cur = den.mag;
    parity = 0;
    while (cur != 0) begin
      t = prev % cur;
      prev = cur;
      cur = t;
      parity = !parity;
    end
    g.mag = prev;
    g.neg = parity ? den.neg : num.neg;
    r.res_num = scaled(num, g);
    r.res_den = scaled(den, g);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    errors_o++;
  endtask

  initial errors_o = 0;
  assign pending_o = expected_q.size();

  always @(posedge clk_i) begin
    rau_pkg::rsp_t want;
    if (rst_ni && req_valid_i && req_ready_i) expected_q.push_back(reduced_fraction(req_data_i));
    if (rst_ni && rsp_valid_i && rsp_ready_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transaction", rsp_data_i.res_num, '0);
      end else begin
        want = expected_q.pop_front();
        if (rsp_data_i.res_num !== want.res_num)
          report_mismatch("res_num", rsp_data_i.res_num, want.res_num);
        if (rsp_data_i.res_den !== want.res_den)
          report_mismatch("res_den", rsp_data_i.res_den, want.res_den);
        if (rsp_data_i.status !== want.status)
          report_mismatch("status", 64'(rsp_data_i.status), 64'(want.status));
      end
    end
  end
endmodule

@@ verif/tb_rational_arithmetic_unit.sv @@
// Testbench top for the rational arithmetic unit: stimulus, stalls and verdict.
`timescale 1ns / 100ps
module tb_rational_arithmetic_unit;
  localparam int unsigned CycleLimit = 8000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int unsigned send_idle_pct = 18;
  int unsigned recv_idle_pct = 52;
  int unsigned hold_cycles = 0;
  int unsigned cycle_count = 0;
  int unsigned errors, pending;

  rau_req_if req_if ();
  rau_rsp_if rsp_if ();

  rational_arithmetic_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  rau_checker checker_u (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_if.valid),
    .req_ready_i(req_if.ready),
    .req_data_i (req_if.data),
    .rsp_valid_i(rsp_if.valid),
    .rsp_ready_i(rsp_if.ready),
    .rsp_data_i (rsp_if.data),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  always #10 clk_i = ~clk_i;

  // result side: random stalls, plus a long hold-off on request
  initial rsp_if.ready = 1'b0;
  always @(posedge clk_i) begin
    if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // timeout watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(int'($urandom_range(20)) - 10);
      3: return 32'($urandom_range(255)) << $urandom_range(24);
      4: return 32'h0;
      default: return $urandom();
    endcase
  endfunction

  // valid drops only while idling, so it gets one update per edge
  task automatic send_request(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
                              logic [31:0] bn, logic [31:0] bd);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= '{op: op, a_num: an, a_den: ad, b_num: bn, b_den: bd};
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
  endtask

  task automatic send_random(int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      send_request(3'($urandom_range(7)), pick_operand(), pick_operand(),
                   pick_operand(), pick_operand());
  endtask

  initial begin
    req_if.valid = 1'b0;
    req_if.data  = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every operation, extremes, zero cases, aliased codes
    send_request(rau_pkg::OpAdd, 32'd1, 32'd2, 32'd1, 32'd3);
    send_request(rau_pkg::OpSub, 32'd1, 32'd2, 32'd1, 32'd2);
    send_request(rau_pkg::OpMul, -32'sd2, 32'd4, 32'd3, -32'sd9);
    send_request(rau_pkg::OpDiv, 32'd3, 32'd4, 32'd0, 32'd5);
    send_request(rau_pkg::OpDiv, -32'sd6, 32'd4, -32'sd3, 32'd8);
    send_request(rau_pkg::OpRed, -32'sd2, 32'd4, 32'd0, 32'd0);
    send_request(rau_pkg::OpRed, 32'd2, -32'sd4, 32'd0, 32'd0);
    send_request(rau_pkg::OpRed, -32'sd2, -32'sd4, 32'd0, 32'd0);
    send_request(rau_pkg::OpRed, 32'd0, 32'd0, 32'd1, 32'd1);
    send_request(rau_pkg::OpMul, 32'd0, 32'd1, 32'd5, 32'd0);
    send_request(rau_pkg::OpAdd, 32'd0, 32'd0, 32'd0, 32'd0);
    send_request(3'd5, 32'd0, 32'd7, 32'hffff_ffff, 32'hffff_ffff);
    send_request(3'd6, 32'h8000_0000, 32'h7fff_ffff, 32'd0, 32'd0);
    send_request(3'd7, 32'h7fff_ffff, 32'h8000_0000, 32'd0, 32'd0);
    send_request(rau_pkg::OpAdd, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                 32'h8000_0000);
    send_request(rau_pkg::OpAdd, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000);
    send_request(rau_pkg::OpSub, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                 32'h8000_0000);
    send_request(rau_pkg::OpMul, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000);
    send_request(rau_pkg::OpDiv, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                 32'h7fff_ffff);
    send_request(rau_pkg::OpDiv, 32'hffff_ffff, 32'h0, 32'h0, 32'h1);

    send_random(60);

    // long receiver hold-off while requests keep coming
    hold_cycles = 20000;
    send_random(5);
    drain();

    send_idle_pct = 52;
    recv_idle_pct = 18;
    send_random(70);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(50);

    drain();
    repeat (100) @(posedge clk_i);
    if (errors == 0 && pending == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

@@ files.f @@
rtl/core/rau_pkg.sv
rtl/core/rau_if.sv
rtl/core/rau_divider.sv
rtl/core/rau_datapath.sv
rtl/core/rau_ctrl.sv
rtl/core/rational_arithmetic_unit.sv
verif/rau_checker.sv
verif/tb_rational_arithmetic_unit.sv
